// ----- sv/pnf_pkg.sv -----
`timescale 1ns / 1ps

package pnf_pkg;

	// Widths of the sample fields and the gain register
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;

	// Default filter state width (signed, 20 fraction bits)
	localparam int PNF_STATE_WIDTH = 24;

	// Coefficients are signed Q*.18 values
	localparam int COEF_W    = 19;
	localparam int NUM_POLES = 6;
	localparam int POLE_IDX_W = $clog2(NUM_POLES);

	// Shifts of the fixed-point pipeline
	localparam int POLE_SHIFT   = 18;
	localparam int POLE_B_SHIFT = 5;
	localparam int TERM_SHIFT   = 13;
	localparam int SCALE_SHIFT  = 12;
	localparam int NOISE_SHIFT  = 21;

	// Scale is gain times the -18.2 dB correction, Q1.16 unsigned
	localparam int SCALE_W = 17;

	localparam logic signed [COEF_W-1:0] DIRECT_COEF = 19'sd140562;
	localparam logic signed [COEF_W-1:0] DELAY_COEF  = 19'sd30389;
	localparam logic signed [COEF_W-1:0] CORR_Q16    = 19'sd8063;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_POLE,
		OP_GAIN_DIRECT,
		OP_DELAY,
		OP_NOISE
	} pnf_op_t;

	typedef struct packed {
		logic                  load;
		pnf_op_t               op;
		logic [POLE_IDX_W-1:0] pole_idx;
		logic                  hold;
	} pnf_cmd_t;

	function automatic logic signed [COEF_W-1:0] pole_a_coef(input logic [POLE_IDX_W-1:0] idx);
		logic signed [COEF_W-1:0] c;
		unique case (idx)
			3'd0: c = 19'sd261845;
			3'd1: c = 19'sd260393;
			3'd2: c = 19'sd254018;
			3'd3: c = 19'sd227148;
			3'd4: c = 19'sd144179;
			3'd5: c = -19'sd199649;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic signed [COEF_W-1:0] pole_b_coef(input logic [POLE_IDX_W-1:0] idx);
		logic signed [COEF_W-1:0] c;
		unique case (idx)
			3'd0: c = 19'sd14554;
			3'd1: c = 19'sd19681;
			3'd2: c = 19'sd40331;
			3'd3: c = 19'sd81392;
			3'd4: c = 19'sd139710;
			3'd5: c = -19'sd4430;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ----- sv/pnf_in_if.sv -----
`timescale 1ns / 1ps

interface pnf_in_if import pnf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] white_sample;
	logic signed [SAMPLE_W-1:0] mix_in;

	modport source (output valid, output white_sample, output mix_in, input ready);
	modport sink (input valid, input white_sample, input mix_in, output ready);
endinterface

// ----- sv/pnf_out_if.sv -----
`timescale 1ns / 1ps

interface pnf_out_if import pnf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] mix_out;

	modport source (output valid, output mix_out, input ready);
	modport sink (input valid, input mix_out, output ready);
endinterface

// ----- sv/pnf_cfg_if.sv -----
`timescale 1ns / 1ps

interface pnf_cfg_if import pnf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [GAIN_W-1:0] noise_gain;

	modport source (output valid, output noise_gain, input ready);
	modport sink (input valid, input noise_gain, output ready);
endinterface

// ----- sv/pink_noise_filter.sv -----
`timescale 1ns / 1ps

// Pink noise generator and mixer. Each transfer on the sample channel brings
// one white-noise sample and one audio sample (both Q1.15). Six one-pole
// sections, five low-pass and one with negative feedback, and a one-sample
// delayed term shape the white noise into pink noise; their sum plus a
// direct term is scaled by noise_gain (Q4.12, reset 4096 = unity) and a
// fixed -18.2 dB correction, added to the audio sample and saturated to 16
// bits. Filter states are signed STATE_WIDTH bits with 20 fraction bits and
// saturate at their range limits; a sustained DC input can drive them
// there. After the transfer the sequencer runs nine steps, sharing a
// coefficient multiplier and a white-sample multiplier over the six poles,
// the direct and delayed terms, the gain scale and the final noise scale,
// then a last step in which the result register loads. The sequencer
// returns to idle on that same edge and takes no new item before then; a
// result that is not taken holds the sequencer in its last step until the
// result register frees up. The next item is accepted while a result still
// waits on the result channel. Write noise_gain only while the block is idle.

module pink_noise_filter import pnf_pkg::*; #(
	parameter int STATE_WIDTH = PNF_STATE_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	pnf_in_if.sink    sample,
	pnf_out_if.source result,
	pnf_cfg_if.sink   cfg
);

	pnf_cmd_t cmd;
	logic     out_free;

	// The gain register takes a write in any cycle.
	assign cfg.ready = 1'b1;

	// Sequencer: accept, step through the taps, then wait for the result
	// register to be free.
	pnf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.out_free (out_free),
		.in_ready (sample.ready),
		.cmd      (cmd)
	);

	// Filter state, multipliers, accumulator and result register.
	pnf_datapath #(
		.STATE_WIDTH (STATE_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.white_sample (sample.white_sample),
		.mix_in       (sample.mix_in),
		.gain_wr      (cfg.valid),
		.gain_data    (cfg.noise_gain),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.out_free     (out_free),
		.mix_out      (result.mix_out)
	);

endmodule

// ----- sv/pnf_ctrl.sv -----
`timescale 1ns / 1ps

module pnf_ctrl import pnf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     out_free,
	output logic     in_ready,
	output pnf_cmd_t cmd
);

	localparam int LAST_POLE_STEP = NUM_POLES - 1;
	localparam int GAIN_STEP      = NUM_POLES;
	localparam int DELAY_STEP     = NUM_POLES + 1;
	localparam int NOISE_STEP     = NUM_POLES + 2;
	localparam int STEP_W         = $clog2(NOISE_STEP + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_valid)
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (step_q == STEP_W'(NOISE_STEP))
						state_q <= ST_FINISH;
					else
						step_q <= step_q + STEP_W'(1);
				end
				ST_FINISH: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.op       = OP_NONE;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.hold     = (state_q == ST_FINISH) && !out_free;
		cmd.pole_idx = step_q[POLE_IDX_W-1:0];
		if (state_q == ST_RUN) begin
			if (step_q <= STEP_W'(LAST_POLE_STEP))
				cmd.op = OP_POLE;
			else if (step_q == STEP_W'(GAIN_STEP))
				cmd.op = OP_GAIN_DIRECT;
			else if (step_q == STEP_W'(DELAY_STEP))
				cmd.op = OP_DELAY;
			else
				cmd.op = OP_NOISE;
		end
	end

endmodule

// ----- sv/pnf_datapath.sv -----
`timescale 1ns / 1ps

module pnf_datapath import pnf_pkg::*; #(
	parameter int STATE_WIDTH = PNF_STATE_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pnf_cmd_t                   cmd,
	input  logic signed [SAMPLE_W-1:0] white_sample,
	input  logic signed [SAMPLE_W-1:0] mix_in,
	input  logic                       gain_wr,
	input  logic [GAIN_W-1:0]          gain_data,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic                       out_free,
	output logic signed [SAMPLE_W-1:0] mix_out
);

	localparam int SUM_W   = STATE_WIDTH + 4;
	localparam int PA_W    = SUM_W + COEF_W;
	localparam int PB_W    = SAMPLE_W + COEF_W;
	localparam int ACC_W   = PA_W + 1;
	localparam int RND_W   = ACC_W - POLE_SHIFT;
	localparam int TERM_W  = PB_W - TERM_SHIFT;
	localparam int NOISE_W = PA_W - NOISE_SHIFT;
	localparam int TOT_W   = NOISE_W + 1;

	localparam logic signed [RND_W-1:0] ST_MAX =
		(RND_W'(1) <<< (STATE_WIDTH - 1)) - RND_W'(1);
	localparam logic signed [RND_W-1:0] ST_MIN = -ST_MAX - RND_W'(1);
	localparam logic signed [TOT_W-1:0] OUT_MAX = TOT_W'(32767);
	localparam logic signed [TOT_W-1:0] OUT_MIN = -TOT_W'(32768);

	function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [RND_W-1:0] x);
		logic signed [STATE_WIDTH-1:0] r;
		if (x > ST_MAX)
			r = ST_MAX[STATE_WIDTH-1:0];
		else if (x < ST_MIN)
			r = ST_MIN[STATE_WIDTH-1:0];
		else
			r = x[STATE_WIDTH-1:0];
		return r;
	endfunction

	logic signed [STATE_WIDTH-1:0] pole_q [NUM_POLES];
	logic signed [STATE_WIDTH-1:0] delay_q;
	logic [GAIN_W-1:0]             gain_q;
	logic signed [SAMPLE_W-1:0]    white_q;
	logic signed [SAMPLE_W-1:0]    mix_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [SCALE_W-1:0]            scale_q;
	logic signed [SAMPLE_W-1:0]    mix_out_q;
	logic                          out_valid_q;

	pnf_op_t                 op_s1;
	logic [POLE_IDX_W-1:0]   idx_s1;
	logic signed [PA_W-1:0]  pa_s1;
	logic signed [PB_W-1:0]  pb_s1;

	logic signed [SUM_W-1:0]  a_op;
	logic signed [COEF_W-1:0] a_coef;
	logic signed [COEF_W-1:0] b_coef;
	logic signed [PA_W-1:0]   pa;
	logic signed [PB_W-1:0]   pb;

	logic signed [ACC_W-1:0]       acc;
	logic signed [STATE_WIDTH-1:0] pole_new;
	logic signed [TERM_W-1:0]      term;
	logic signed [PA_W-1:0]        scale_full;
	logic signed [NOISE_W-1:0]     noise;
	logic signed [TOT_W-1:0]       total;
	logic signed [SAMPLE_W-1:0]    total_sat;
	logic                          out_load;

	// Operand select for the two multipliers
	always_comb begin
		a_op   = '0;
		a_coef = '0;
		b_coef = '0;
		case (cmd.op)
			OP_POLE: begin
				a_op   = SUM_W'(pole_q[cmd.pole_idx]);
				a_coef = pole_a_coef(cmd.pole_idx);
				b_coef = pole_b_coef(cmd.pole_idx);
			end
			OP_GAIN_DIRECT: begin
				a_op   = SUM_W'(gain_q);
				a_coef = CORR_Q16;
				b_coef = DIRECT_COEF;
			end
			OP_DELAY: begin
				b_coef = DELAY_COEF;
			end
			OP_NOISE: begin
				a_op   = sum_q;
				a_coef = COEF_W'(scale_q);
			end
			default: begin
				a_op = '0;
			end
		endcase
	end

	assign pa = a_op * a_coef;
	assign pb = white_q * b_coef;

	// Second stage: round, saturate, accumulate
	always_comb begin
		acc = ACC_W'(pa_s1) + (ACC_W'(pb_s1) <<< POLE_B_SHIFT)
			+ (ACC_W'(1) <<< (POLE_SHIFT - 1));
		pole_new = sat_state(RND_W'(acc >>> POLE_SHIFT));
		term = TERM_W'((pb_s1 + (PB_W'(1) <<< (TERM_SHIFT - 1))) >>> TERM_SHIFT);
		scale_full = (pa_s1 + (PA_W'(1) <<< (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
		noise = NOISE_W'((pa_s1 + (PA_W'(1) <<< (NOISE_SHIFT - 1))) >>> NOISE_SHIFT);
		total = TOT_W'(mix_q) + TOT_W'(noise);
		if (total > OUT_MAX)
			total_sat = OUT_MAX[SAMPLE_W-1:0];
		else if (total < OUT_MIN)
			total_sat = OUT_MIN[SAMPLE_W-1:0];
		else
			total_sat = total[SAMPLE_W-1:0];
	end

	assign out_free = !out_valid_q || out_ready;
	assign out_load = (op_s1 == OP_NOISE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_POLES; i++)
				pole_q[i] <= '0;
			delay_q     <= '0;
			gain_q      <= GAIN_RESET;
			op_s1       <= OP_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (gain_wr)
				gain_q <= gain_data;
			if (!cmd.hold)
				op_s1 <= cmd.op;
			if (op_s1 == OP_POLE)
				pole_q[idx_s1] <= pole_new;
			if (op_s1 == OP_DELAY)
				delay_q <= sat_state(RND_W'(term));
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			white_q <= white_sample;
			mix_q   <= mix_in;
			sum_q   <= SUM_W'(delay_q);
		end else if (op_s1 == OP_POLE) begin
			sum_q <= sum_q + SUM_W'(pole_new);
		end else if (op_s1 == OP_GAIN_DIRECT) begin
			sum_q <= sum_q + SUM_W'(term);
		end
		if (op_s1 == OP_GAIN_DIRECT)
			scale_q <= scale_full[SCALE_W-1:0];
		if (!cmd.hold) begin
			idx_s1 <= cmd.pole_idx;
			pa_s1  <= pa;
			pb_s1  <= pb;
		end
		if (out_load)
			mix_out_q <= total_sat;
	end

	assign out_valid = out_valid_q;
	assign mix_out   = mix_out_q;

endmodule

// ----- tb/pink_noise_filter_tb.sv -----
`timescale 1ns / 1ps

module pink_noise_filter_tb;
	import pnf_pkg::*;

	localparam int SW            = PNF_STATE_WIDTH;
	localparam int SETTLE_CYCLES = 16;      // extra wait after the last result has come back
	localparam int LIMIT_CYCLES  = 400000;
	localparam int MAX_REPORTS   = 10;

	// Kellet refined taps, scaled by 2^18 (a: feedback, b: white-sample weight)
	localparam longint POLE_FB [6] = '{261845, 260393, 254018, 227148, 144179, -199649};
	localparam longint POLE_IN [6] = '{14554, 19681, 40331, 81392, 139710, -4430};
	localparam longint DIRECT_TAP  = 140562;
	localparam longint DELAY_TAP   = 30389;
	localparam longint ATTEN_Q16   = 8063;  // -18.2 dB in Q0.16

	logic clk;
	logic arst_n;

	pnf_in_if  sample_ch ();
	pnf_out_if result_ch ();
	pnf_cfg_if cfg_ch ();

	pink_noise_filter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Filter state of the predictor, mirrors the block after reset
	logic signed [SW-1:0]       pole_q [6] = '{default: '0};
	logic signed [SW-1:0]       delay_q    = '0;
	logic [GAIN_W-1:0]          gain_q     = GAIN_RESET;

	// Expected mix_out values, oldest first
	logic signed [SAMPLE_W-1:0] pending_mix [$];

	int src_idle_pct = 34;
	int rcv_idle_pct = 49;
	int mismatches   = 0;
	int cycles       = 0;

	// Directed stimulus: a gain write may precede a row; typed rows carry
	// an expectation that is obvious by inspection
	typedef struct packed {
		bit                         set_gain;
		logic [GAIN_W-1:0]          gain;
		logic signed [SAMPLE_W-1:0] white;
		logic signed [SAMPLE_W-1:0] mix;
		bit                         typed;
		logic signed [SAMPLE_W-1:0] mix_exp;
	} stim_row_t;

	localparam int N_ROWS = 22;

	stim_row_t directed_rows [N_ROWS] = '{
		// fresh after reset: all state zero, so noise is zero
		'{1'b0, 16'd0,     16'sd0,      16'sd0,      1'b1, 16'sd0},
		'{1'b0, 16'd0,     16'sd0,      16'sd32767,  1'b1, 16'sd32767},
		'{1'b0, 16'd0,     16'sd0,     -16'sd32768,  1'b1, -16'sd32768},
		// full-scale noise on a full-scale sample clips the output
		'{1'b0, 16'd0,     16'sd32767,  16'sd32767,  1'b1, 16'sd32767},
		'{1'b0, 16'd0,    -16'sd32768, -16'sd32768,  1'b1, -16'sd32768},
		'{1'b0, 16'd0,     16'sd0,      16'sd0,      1'b0, 16'sd0},
		'{1'b0, 16'd0,     16'sd1,     -16'sd1,      1'b0, 16'sd0},
		'{1'b0, 16'd0,    -16'sd1,      16'sd1,      1'b0, 16'sd0},
		'{1'b0, 16'd0,     16'sd16384,  16'sd0,      1'b0, 16'sd0},
		'{1'b0, 16'd0,    -16'sd16384,  16'sd12345,  1'b0, 16'sd0},
		// largest gain
		'{1'b1, 16'hFFFF,  16'sd32767,  16'sd0,      1'b0, 16'sd0},
		'{1'b0, 16'd0,    -16'sd32768,  16'sd0,      1'b0, 16'sd0},
		'{1'b0, 16'd0,     16'sd21845, -16'sd21846,  1'b0, 16'sd0},
		// zero gain passes mix_in straight through
		'{1'b1, 16'd0,     16'sd32767,  16'sd1000,   1'b1, 16'sd1000},
		'{1'b0, 16'd0,    -16'sd32768, -16'sd32768,  1'b1, -16'sd32768},
		'{1'b0, 16'd0,     16'sd12345,  16'sd32767,  1'b1, 16'sd32767},
		// smallest nonzero gain
		'{1'b1, 16'd1,     16'sd32767,  16'sd0,      1'b0, 16'sd0},
		'{1'b0, 16'd0,    -16'sd32768, -16'sd1,      1'b0, 16'sd0},
		// back to unity
		'{1'b1, 16'd4096,  16'sd0,      16'sd100,    1'b0, 16'sd0},
		'{1'b0, 16'd0,     16'sd32767, -16'sd32768,  1'b0, 16'sd0},
		'{1'b0, 16'd0,    -16'sd32768,  16'sd32767,  1'b0, 16'sd0},
		'{1'b0, 16'd0,     16'sd0,      16'sd0,      1'b0, 16'sd0}
	};

	// Round half up: add half an LSB of the target, then floor
	function automatic longint round_shift(input longint x, input int k);
		return (x + (longint'(1) <<< (k - 1))) >>> k;
	endfunction

	function automatic logic signed [SW-1:0] clamp_state(input longint x);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (SW - 1)) - 1;
		lo = -(longint'(1) <<< (SW - 1));
		if (x > hi)
			return hi[SW-1:0];
		if (x < lo)
			return lo[SW-1:0];
		return x[SW-1:0];
	endfunction

	// Advance the pink filter by one white sample and return the mixed output
	function automatic logic signed [SAMPLE_W-1:0] pink_mix_predict(
		input logic signed [SAMPLE_W-1:0] white,
		input logic signed [SAMPLE_W-1:0] mix
	);
		longint w;
		longint acc;
		longint pink_sum;
		longint scale;
		longint noise;
		longint total;
		w = longint'(white);
		pink_sum = 0;
		for (int i = 0; i < 6; i++) begin
			acc = longint'(pole_q[i]) * POLE_FB[i] + w * POLE_IN[i] * 32;
			pole_q[i] = clamp_state(round_shift(acc, 18));
			pink_sum += longint'(pole_q[i]);
		end
		// delayed term enters with its old value, then takes the new sample
		pink_sum += longint'(delay_q);
		pink_sum += round_shift(w * DIRECT_TAP, 13);
		delay_q = clamp_state(round_shift(w * DELAY_TAP, 13));

		scale = round_shift(longint'(gain_q) * ATTEN_Q16, 12);
		noise = round_shift(pink_sum * scale, 21);
		total = longint'(mix) + noise;
		if (total > 32767)
			total = 32767;
		if (total < -32768)
			total = -32768;
		return total[SAMPLE_W-1:0];
	endfunction

	// Offer one sample item; record its expected result on transfer.
	// Valid stays high on return so back-to-back items need no dip.
	task automatic put_sample(
		input logic signed [SAMPLE_W-1:0] white,
		input logic signed [SAMPLE_W-1:0] mix,
		input bit                         typed,
		input logic signed [SAMPLE_W-1:0] typed_mix
	);
		logic signed [SAMPLE_W-1:0] predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.white_sample <= white;
		sample_ch.mix_in       <= mix;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		// the predictor runs for every row to keep its state in step
		predicted = pink_mix_predict(white, mix);
		pending_mix.push_back(typed ? typed_mix : predicted);
	endtask

	// Drop valid and hold until every expected result has come back
	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		while (pending_mix.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_gain(input logic [GAIN_W-1:0] gain);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.noise_gain <= gain;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		gain_q = gain;
	endtask

	// Random white noise in segments: plain noise, long and short DC runs (the
	// long ones can saturate the slow poles), small signals, alternating extremes
	task automatic run_noise(input int count);
		int                         left;
		int                         len;
		int                         kind;
		logic signed [SAMPLE_W-1:0] level;
		logic signed [SAMPLE_W-1:0] white;
		logic signed [SAMPLE_W-1:0] mix;
		left = count;
		while (left > 0) begin
			kind = $urandom_range(9);
			case ($urandom_range(2))
				0: level = 16'sh7FFF;
				1: level = 16'sh8000;
				default: level = SAMPLE_W'($urandom);
			endcase
			if (kind == 5 || kind == 6)
				len = $urandom_range(150, 250);
			else
				len = $urandom_range(10, 60);
			if (len > left)
				len = left;
			for (int k = 0; k < len; k++) begin
				case (kind)
					5, 6, 9: white = level;
					7: white = SAMPLE_W'($urandom_range(511) - 256);
					8: white = k[0] ? 16'sh7FFF : 16'sh8000;
					default: white = SAMPLE_W'($urandom);
				endcase
				if ($urandom_range(9) < 2) begin
					case ($urandom_range(2))
						0: mix = 16'sh7FFF;
						1: mix = 16'sh8000;
						default: mix = '0;
					endcase
				end else begin
					mix = SAMPLE_W'($urandom);
				end
				put_sample(white, mix, 1'b0, '0);
			end
			left -= len;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result side: check each transfer against the oldest expectation and
	// throttle ready. Every 400 results, hold ready low for a long stretch so
	// the block backs up and stalls its sample input.
	initial begin : result_sink
		int                         results_seen;
		int                         hold_left;
		logic signed [SAMPLE_W-1:0] want;
		results_seen = 0;
		hold_left    = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (pending_mix.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("unexpected result: mix_out %0d", result_ch.mix_out);
					mismatches++;
				end else begin
					want = pending_mix.pop_front();
					if (result_ch.mix_out !== want) begin
						if (mismatches < MAX_REPORTS)
							$display("mix_out mismatch at result %0d: expected %0d, got %0d",
								results_seen, want, result_ch.mix_out);
						mismatches++;
					end
				end
				if (results_seen % 400 == 150)
					hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// Stimulus
	initial begin
		arst_n                 <= 1'b0;
		sample_ch.valid        <= 1'b0;
		sample_ch.white_sample <= '0;
		sample_ch.mix_in       <= '0;
		cfg_ch.valid           <= 1'b0;
		cfg_ch.noise_gain      <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: gain writes only once the block has drained
		for (int r = 0; r < N_ROWS; r++) begin
			if (directed_rows[r].set_gain) begin
				wait_idle();
				write_gain(directed_rows[r].gain);
			end
			put_sample(directed_rows[r].white, directed_rows[r].mix,
				directed_rows[r].typed, directed_rows[r].mix_exp);
		end

		// Sender idles more rarely than the receiver; random gain.
		// Open with a positive full-scale DC run to saturate the slow poles.
		wait_idle();
		write_gain(GAIN_W'($urandom_range(65535)));
		for (int k = 0; k < 180; k++)
			put_sample(16'sh7FFF, SAMPLE_W'($urandom), 1'b0, '0);
		run_noise(140);

		// Swap the idle rates; largest gain
		wait_idle();
		src_idle_pct = 49;
		rcv_idle_pct = 34;
		write_gain(16'hFFFF);
		run_noise(160);
		// pause the sender until the block is empty, then resume
		wait_idle();
		run_noise(160);

		// No idling on either side; negative DC run first
		wait_idle();
		src_idle_pct = 0;
		rcv_idle_pct = 0;
		write_gain(GAIN_W'($urandom_range(2048, 12288)));
		for (int k = 0; k < 180; k++)
			put_sample(16'sh8000, SAMPLE_W'($urandom), 1'b0, '0);
		run_noise(130);

		wait_idle();
		if (mismatches == 0 && pending_mix.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
